// File: src/gdc_pkg.sv
package gdc_pkg;

   localparam int MAX_YEAR_DEFAULT = 9999;

   // Reciprocal constants: x/100 = (x*5243)>>19 for x < 2^14,
   // x/7 = (x*586)>>12 for x < 2^9
   localparam int RECIP_100       = 5243;
   localparam int RECIP_100_SHIFT = 19;
   localparam int RECIP_7         = 586;
   localparam int RECIP_7_SHIFT   = 12;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;
   localparam logic [3:0] WEEKDAY_BASE = 4'd2;

   typedef struct packed {
      logic [4:0]  day_in;
      logic [3:0]  month_in;
      logic [13:0] year_in;
      logic [3:0]  first_weekday;
   } req_type;

   typedef struct packed {
      logic        date_valid;
      logic        leap_year;
      logic [4:0]  month_length;
      logic [4:0]  next_day;
      logic [3:0]  next_month;
      logic [13:0] next_year;
      logic [4:0]  prev_day;
      logic [3:0]  prev_month;
      logic [13:0] prev_year;
      logic [8:0]  ordinal_in_year;
      logic [21:0] absolute_day;
      logic [3:0]  weekday_out;
   } rsp_type;

   // Days in month; 0 for a month code outside 1..12
   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the year before the first of month m (non-leap)
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] dbm;
      case (m)
         4'd2:    dbm = 9'd31;
         4'd3:    dbm = 9'd59;
         4'd4:    dbm = 9'd90;
         4'd5:    dbm = 9'd120;
         4'd6:    dbm = 9'd151;
         4'd7:    dbm = 9'd181;
         4'd8:    dbm = 9'd212;
         4'd9:    dbm = 9'd243;
         4'd10:   dbm = 9'd273;
         4'd11:   dbm = 9'd304;
         4'd12:   dbm = 9'd334;
         default: dbm = 9'd0;
      endcase
      return dbm;
   endfunction

   // floor(x/100) for a 14-bit value
   function automatic logic [13:0] div100(input logic [13:0] x);
      logic [26:0] prod;
      prod = 27'(x) * 27'(RECIP_100);
      return 14'(prod >> RECIP_100_SHIFT);
   endfunction

   // x mod 7 for a 9-bit value
   function automatic logic [2:0] mod7_9(input logic [8:0] x);
      logic [18:0] prod;
      logic [8:0]  q;
      logic [8:0]  r;
      prod = 19'(x) * 19'(RECIP_7);
      q    = 9'(prod >> RECIP_7_SHIFT);
      r    = x - 9'(q * 9'd7);
      return r[2:0];
   endfunction

   // x mod 7 for a value below 21
   function automatic logic [2:0] mod7_small(input logic [4:0] x);
      logic [4:0] r;
      if (x >= 5'd14) begin
         r = x - 5'd14;
      end else if (x >= 5'd7) begin
         r = x - 5'd7;
      end else begin
         r = x;
      end
      return r[2:0];
   endfunction

endpackage

// File: src/gregorian_date_calculator_core.sv
// Gregorian date calculator.
// Input channel req_*: one beat carries a date (day, month, year) and the
// weekday of 1 January of that year. Output channel rsp_*: one beat per input
// beat, in order, with the validity flag, leap flag, month length, next and
// previous date, ordinal day, day count from 1/1/1 and the weekday.
// The pipeline has three register stages: divide-by-reciprocal and year*365,
// calendar decode and base sum, date stepping and weekday. Throughput: one
// beat per cycle while the output is not stalled.
// A stage holding a beat advances when the stage after it is empty or
// advancing, so bubbles close up while the output is stalled and req_stall
// rises only when all three stages hold beats and rsp_stall is high.
// A stalled rsp beat holds its payload until taken.
// Reset (synchronous) empties the pipeline; the payload registers are not reset.
module gregorian_date_calculator_core #(
   parameter int MAX_YEAR = gdc_pkg::MAX_YEAR_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gdc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gdc_pkg::rsp_type rsp_data
);
   import gdc_pkg::*;

   // stage 1 registers
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff;
   logic [13:0] s1_qy_ff, s1_qb_ff;
   logic [21:0] s1_y365_ff;

   // stage 2 registers
   logic        s2_valid_ff, s2_valid_in;
   req_type     s2_req_ff;
   logic        s2_date_ok_ff, s2_leap_ff;
   logic [4:0]  s2_len_ff;
   logic [8:0]  s2_ord_ff;
   logic [21:0] s2_base_ff;
   logic [2:0]  s2_fwm_ff;

   // output registers
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic en1, en2, en3;

   // stage 1 combinational
   logic [13:0] yb1;
   logic [13:0] qy_in, qb_in;
   logic [21:0] y365_in;

   // stage 2 combinational
   logic [13:0] y2, yb2, r100;
   logic        leap_in, date_ok_in;
   logic [4:0]  len_in;
   logic [8:0]  ord_in;
   logic [21:0] base_in;
   logic [2:0]  fwm_in;

   // stage 3 combinational
   logic [2:0]  ordm;
   logic [3:0]  wsum;
   logic [2:0]  wmod;

   // advance when downstream slot is free or moving
   assign en3       = !rsp_valid_ff || !rsp_stall;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   assign s1_valid_in  = en1 ? req_valid : s1_valid_ff;
   assign s2_valid_in  = en2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = en3 ? s2_valid_ff : rsp_valid_ff;

   // stage 1: quotients by 100 and year*365
   always_comb begin
      yb1     = req_data.year_in - 14'd1;
      qy_in   = div100(req_data.year_in);
      qb_in   = div100(yb1);
      y365_in = 22'(yb1) * 22'd365;
   end

   // stage 2: leap, month length, validity, ordinal, base day count, weekday offset
   always_comb begin
      y2         = s1_req_ff.year_in;
      yb2        = y2 - 14'd1;
      r100       = y2 - 14'(s1_qy_ff * 14'd100);
      leap_in    = (r100 == 14'd0) ? (s1_qy_ff[1:0] == 2'd0) : (y2[1:0] == 2'd0);
      len_in     = month_days(s1_req_ff.month_in, leap_in);
      date_ok_in = (y2 != 14'd0) && (32'(y2) <= MAX_YEAR) &&
                   (s1_req_ff.day_in != 5'd0) && (s1_req_ff.day_in <= len_in);
      ord_in     = days_before(s1_req_ff.month_in) + 9'(s1_req_ff.day_in) +
                   9'(leap_in && (s1_req_ff.month_in > MONTH_FEB));
      base_in    = s1_y365_ff + 22'(yb2 >> 2) - 22'(s1_qb_ff) + 22'(s1_qb_ff >> 2);
      fwm_in     = mod7_small(5'(s1_req_ff.first_weekday) + 5'd5);
   end

   // stage 3: next/previous date, day count, weekday
   always_comb begin
      ordm = mod7_9(s2_ord_ff - 9'd1);
      wsum = 4'(s2_fwm_ff) + 4'(ordm);
      wmod = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];

      rsp_data_in              = '0;
      rsp_data_in.date_valid   = s2_date_ok_ff;
      rsp_data_in.leap_year    = s2_leap_ff;
      rsp_data_in.month_length = s2_len_ff;
      if (s2_date_ok_ff) begin
         // following date
         rsp_data_in.next_day   = s2_req_ff.day_in + 5'd1;
         rsp_data_in.next_month = s2_req_ff.month_in;
         rsp_data_in.next_year  = s2_req_ff.year_in;
         if (s2_req_ff.day_in == s2_len_ff) begin
            rsp_data_in.next_day = 5'd1;
            if (s2_req_ff.month_in == MONTH_DEC) begin
               rsp_data_in.next_month = MONTH_JAN;
               rsp_data_in.next_year  = s2_req_ff.year_in + 14'd1;
            end else begin
               rsp_data_in.next_month = s2_req_ff.month_in + 4'd1;
            end
         end
         // preceding date
         rsp_data_in.prev_day   = s2_req_ff.day_in - 5'd1;
         rsp_data_in.prev_month = s2_req_ff.month_in;
         rsp_data_in.prev_year  = s2_req_ff.year_in;
         if (s2_req_ff.day_in == 5'd1) begin
            if (s2_req_ff.month_in == MONTH_JAN) begin
               rsp_data_in.prev_month = MONTH_DEC;
               rsp_data_in.prev_year  = s2_req_ff.year_in - 14'd1;
               rsp_data_in.prev_day   = month_days(MONTH_DEC, 1'b0);
            end else begin
               rsp_data_in.prev_month = s2_req_ff.month_in - 4'd1;
               rsp_data_in.prev_day   = month_days(s2_req_ff.month_in - 4'd1, s2_leap_ff);
            end
         end
         rsp_data_in.ordinal_in_year = s2_ord_ff;
         rsp_data_in.absolute_day    = s2_base_ff + 22'(s2_ord_ff);
         rsp_data_in.weekday_out     = 4'(wmod) + WEEKDAY_BASE;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_req_ff  <= req_data;
         s1_qy_ff   <= qy_in;
         s1_qb_ff   <= qb_in;
         s1_y365_ff <= y365_in;
      end
      if (en2) begin
         s2_req_ff     <= s1_req_ff;
         s2_date_ok_ff <= date_ok_in;
         s2_leap_ff    <= leap_in;
         s2_len_ff     <= len_in;
         s2_ord_ff     <= ord_in;
         s2_base_ff    <= base_in;
         s2_fwm_ff     <= fwm_in;
      end
      if (en3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/gdc_checker.sv
module gdc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input gdc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gdc_pkg::rsp_type rsp_data
);
   import gdc_pkg::*;

   // a stalled rsp beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // invalid date clears day count, weekday, ordinal and next day
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.date_valid |->
         rsp_data.absolute_day == 22'd0 && rsp_data.weekday_out == 4'd0 &&
         rsp_data.ordinal_in_year == 9'd0 && rsp_data.next_day == 5'd0)
      else $error("derived fields nonzero for invalid date");

   // valid date: weekday code and ordinal in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.date_valid |->
         rsp_data.weekday_out >= 4'd2 && rsp_data.weekday_out <= 4'd8 &&
         rsp_data.ordinal_in_year >= 9'd1 && rsp_data.ordinal_in_year <= 9'd366)
      else $error("weekday or ordinal out of range");

   // valid date: month length at least 28 and 29 only in a leap year, next year not below previous year
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.date_valid |->
         rsp_data.month_length >= 5'd28 &&
         (rsp_data.month_length != 5'd29 || rsp_data.leap_year) &&
         rsp_data.next_year >= rsp_data.prev_year)
      else $error("inconsistent month length or date stepping");

   // pipeline is free whenever the output side is not stalled
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled without output stall");

endmodule

bind gregorian_date_calculator_core gdc_checker u_gdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
